>>> hdl/cyrillic_text_transcoder_macros.svh
// ----------------------------------------------------------------------------
// cyrillic_text_transcoder_macros
// Assertion macros shared by the transcoder modules.
// ----------------------------------------------------------------------------
`ifndef CYRILLIC_TEXT_TRANSCODER_MACROS_SVH
`define CYRILLIC_TEXT_TRANSCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CYTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CYTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cytt_pkg.sv
// ----------------------------------------------------------------------------
// cytt_pkg
// Types, constants and character mapping functions of the transcoder.
// ----------------------------------------------------------------------------
package cytt_pkg;

  localparam int UNIT_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [UNIT_W-1:0] ASCII_LIM   = 16'h0080;
  localparam logic [BYTE_W-1:0] CP_LETTER_LO = 8'hC0;
  localparam logic [BYTE_W-1:0] CP_LETTER_HI = 8'hFF;
  localparam logic [BYTE_W-1:0] CP_IO       = 8'hA8;
  localparam logic [BYTE_W-1:0] CP_YO       = 8'hB8;
  localparam logic [UNIT_W-1:0] CP_OFS      = 16'h0350;
  localparam logic [UNIT_W-1:0] WIDE_IO     = 16'h0401;
  localparam logic [UNIT_W-1:0] WIDE_YO     = 16'h0451;
  localparam logic [UNIT_W-1:0] WIDE_LO     = 16'h0410;
  localparam logic [UNIT_W-1:0] WIDE_MID_HI = 16'h043F;
  localparam logic [UNIT_W-1:0] WIDE_MID_LO = 16'h0440;
  localparam logic [UNIT_W-1:0] WIDE_HI     = 16'h044F;
  localparam logic [UNIT_W-1:0] U8_A_LO     = 16'hD090;
  localparam logic [UNIT_W-1:0] U8_A_HI     = 16'hD0BF;
  localparam logic [UNIT_W-1:0] U8_B_LO     = 16'hD180;
  localparam logic [UNIT_W-1:0] U8_B_HI     = 16'hD18F;
  localparam logic [UNIT_W-1:0] U8_OFS_A    = 16'hCC80;
  localparam logic [UNIT_W-1:0] U8_OFS_B    = 16'hCD40;
  localparam logic [UNIT_W-1:0] U8_IO       = 16'hD081;
  localparam logic [UNIT_W-1:0] U8_YO       = 16'hD191;

  typedef enum logic {
    REG_DIRECTION = 1'b0,
    REG_CODE_PAGE = 1'b1
  } reg_idx_t;

  typedef enum logic {
    DIR_DECODE = 1'b0,
    DIR_ENCODE = 1'b1
  } dir_t;

  typedef enum logic {
    PAGE_CP1251 = 1'b0,
    PAGE_UTF8   = 1'b1
  } page_t;

  typedef struct packed {
    dir_t  direction;
    page_t code_page;
  } cfg_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              bad_char;
    logic              run_last;
    logic              string_last;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [UNIT_W-1:0] val;
  } map_t;

  // conversion stage to output buffer
  typedef struct packed {
    logic    valid;
    logic    emit;
    logic    pair;
    result_t first;
    result_t second;
  } conv_t;

  function automatic map_t cp1251_to_wide(input logic [BYTE_W-1:0] b);
    map_t m;
    m = '0;
    if (b inside {[CP_LETTER_LO:CP_LETTER_HI]}) begin
      m.ok  = 1'b1;
      m.val = {{(UNIT_W-BYTE_W){1'b0}}, b} + CP_OFS;
    end else if (b == CP_IO) begin
      m.ok  = 1'b1;
      m.val = WIDE_IO;
    end else if (b == CP_YO) begin
      m.ok  = 1'b1;
      m.val = WIDE_YO;
    end
    return m;
  endfunction

  function automatic map_t utf8_pair_to_wide(input logic [UNIT_W-1:0] v);
    map_t m;
    m = '0;
    if (v inside {[U8_A_LO:U8_A_HI]}) begin
      m.ok  = 1'b1;
      m.val = v - U8_OFS_A;
    end else if (v inside {[U8_B_LO:U8_B_HI]}) begin
      m.ok  = 1'b1;
      m.val = v - U8_OFS_B;
    end else if (v == U8_IO) begin
      m.ok  = 1'b1;
      m.val = WIDE_IO;
    end else if (v == U8_YO) begin
      m.ok  = 1'b1;
      m.val = WIDE_YO;
    end
    return m;
  endfunction

  function automatic map_t wide_to_cp1251(input logic [UNIT_W-1:0] w);
    map_t              m;
    logic [UNIT_W-1:0] d;
    m = '0;
    d = w - CP_OFS;
    if (w inside {[WIDE_LO:WIDE_HI]}) begin
      m.ok  = 1'b1;
      m.val = {{(UNIT_W-BYTE_W){1'b0}}, d[BYTE_W-1:0]};
    end else if (w == WIDE_IO) begin
      m.ok  = 1'b1;
      m.val = {{(UNIT_W-BYTE_W){1'b0}}, CP_IO};
    end else if (w == WIDE_YO) begin
      m.ok  = 1'b1;
      m.val = {{(UNIT_W-BYTE_W){1'b0}}, CP_YO};
    end
    return m;
  endfunction

  function automatic map_t wide_to_utf8_pair(input logic [UNIT_W-1:0] w);
    map_t m;
    m = '0;
    if (w inside {[WIDE_LO:WIDE_MID_HI]}) begin
      m.ok  = 1'b1;
      m.val = w + U8_OFS_A;
    end else if (w inside {[WIDE_MID_LO:WIDE_HI]}) begin
      m.ok  = 1'b1;
      m.val = w + U8_OFS_B;
    end else if (w == WIDE_IO) begin
      m.ok  = 1'b1;
      m.val = U8_IO;
    end else if (w == WIDE_YO) begin
      m.ok  = 1'b1;
      m.val = U8_YO;
    end
    return m;
  endfunction

endpackage

>>> hdl/cytt_cfg.sv
// ----------------------------------------------------------------------------
// cytt_cfg
// APB-style register bank holding direction and code page.
// ----------------------------------------------------------------------------
module cytt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cytt_pkg::ADDR_W-1:0] paddr,
  input  logic [cytt_pkg::DATA_W-1:0] pwdata,
  output logic [cytt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output cytt_pkg::cfg_t              cfg,
  output logic                        clr
);
  import cytt_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign clr    = wr_en;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DIRECTION: cfg_nxt.direction = dir_t'(pwdata[0]);
        REG_CODE_PAGE: cfg_nxt.code_page = page_t'(pwdata[0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIRECTION: prdata = {{(DATA_W-1){1'b0}}, cfg_r.direction};
      REG_CODE_PAGE: prdata = {{(DATA_W-1){1'b0}}, cfg_r.code_page};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{direction: DIR_DECODE, code_page: PAGE_CP1251};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/cytt_conv.sv
// ----------------------------------------------------------------------------
// cytt_conv
// Input register, character mapping and string state (lead byte, abort).
// ----------------------------------------------------------------------------
`include "cyrillic_text_transcoder_macros.svh"

module cytt_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cytt_pkg::cfg_t              cfg,
  input  logic                        clr,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cytt_pkg::UNIT_W-1:0] in_code_unit,
  input  logic                        in_string_end,
  input  logic                        ready,
  output cytt_pkg::conv_t             conv
);
  import cytt_pkg::*;

  logic              in_v_r;
  logic [UNIT_W-1:0] unit_r;
  logic              end_r;
  logic [BYTE_W-1:0] lead_r;
  logic [BYTE_W-1:0] lead_nxt;
  logic              pending_r;
  logic              pending_nxt;
  logic              aborted_r;
  logic              aborted_nxt;
  logic              take;
  logic              hi_zero;
  logic              ascii;
  logic              hold;
  logic              two;
  map_t              m;

  assign in_stall = in_v_r && !ready;
  assign take     = in_v_r && ready;
  assign hi_zero  = (unit_r[UNIT_W-1:BYTE_W] == '0);
  assign ascii    = (unit_r < ASCII_LIM);

  // mapping
  always_comb begin
    m    = '0;
    hold = 1'b0;
    two  = 1'b0;
    if (cfg.direction == DIR_DECODE) begin
      if (pending_r) begin
        m    = utf8_pair_to_wide({lead_r, unit_r[BYTE_W-1:0]});
        m.ok = m.ok && hi_zero;
      end else if (ascii) begin
        m.ok  = 1'b1;
        m.val = unit_r;
      end else if (!hi_zero) begin
        m.ok = 1'b0;
      end else if (cfg.code_page == PAGE_CP1251) begin
        m = cp1251_to_wide(unit_r[BYTE_W-1:0]);
      end else if (end_r) begin
        m.ok = 1'b0;
      end else begin
        hold = 1'b1;
      end
    end else begin
      if (ascii) begin
        m.ok  = 1'b1;
        m.val = unit_r;
      end else if (cfg.code_page == PAGE_CP1251) begin
        m = wide_to_cp1251(unit_r);
      end else begin
        m   = wide_to_utf8_pair(unit_r);
        two = 1'b1;
      end
    end
  end

  // result build
  always_comb begin
    conv        = '0;
    conv.valid  = in_v_r;
    if (!aborted_r && !hold) begin
      conv.emit = 1'b1;
      if (!m.ok) begin
        conv.first = '{unit: '0, bad_char: 1'b1, run_last: 1'b1, string_last: 1'b1};
      end else if (two) begin
        conv.pair   = 1'b1;
        conv.first  = '{unit: {{(UNIT_W-BYTE_W){1'b0}}, m.val[UNIT_W-1:BYTE_W]},
                        bad_char: 1'b0, run_last: 1'b0, string_last: 1'b0};
        conv.second = '{unit: {{(UNIT_W-BYTE_W){1'b0}}, m.val[BYTE_W-1:0]},
                        bad_char: 1'b0, run_last: 1'b1, string_last: end_r};
      end else begin
        conv.first = '{unit: m.val, bad_char: 1'b0, run_last: 1'b1, string_last: end_r};
      end
    end
  end

  // string state
  always_comb begin
    lead_nxt    = lead_r;
    pending_nxt = pending_r;
    aborted_nxt = aborted_r;
    if (clr) begin
      lead_nxt    = '0;
      pending_nxt = 1'b0;
      aborted_nxt = 1'b0;
    end else if (take) begin
      if (aborted_r) begin
        aborted_nxt = !end_r;
      end else begin
        aborted_nxt = !hold && !m.ok && !end_r;
        pending_nxt = hold;
        lead_nxt    = hold ? unit_r[BYTE_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      lead_r    <= '0;
      pending_r <= 1'b0;
      aborted_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      lead_r    <= lead_nxt;
      pending_r <= pending_nxt;
      aborted_r <= aborted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      unit_r <= in_code_unit;
      end_r  <= in_string_end;
    end
  end

  `CYTT_ASSERT_IMP(a_lead_mode, pending_r,
    (cfg.direction == DIR_DECODE) && (cfg.code_page == PAGE_UTF8),
    "lead byte held outside utf-8 decode")
  `CYTT_ASSERT_IMP(a_lead_abort, pending_r, !aborted_r,
    "lead byte held in an aborted string")

endmodule

>>> hdl/cytt_obuf.sv
// ----------------------------------------------------------------------------
// cytt_obuf
// Result register with a second slot for the trailing utf-8 byte.
// ----------------------------------------------------------------------------
`include "cyrillic_text_transcoder_macros.svh"

module cytt_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  cytt_pkg::conv_t   conv,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output cytt_pkg::result_t out_res
);
  import cytt_pkg::*;

  logic    out_v_r;
  logic    out_v_nxt;
  result_t out_r;
  result_t out_nxt;
  logic    sec_v_r;
  logic    sec_v_nxt;
  result_t sec_r;
  result_t sec_nxt;
  logic    out_free;
  logic    take;

  assign out_free  = !out_v_r || !out_stall;
  assign ready     = out_free && !sec_v_r;
  assign take      = conv.valid && ready;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    sec_v_nxt = sec_v_r;
    sec_nxt   = sec_r;
    if (out_free) begin
      if (sec_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = sec_r;
        sec_v_nxt = 1'b0;
      end else if (take && conv.emit) begin
        out_v_nxt = 1'b1;
        out_nxt   = conv.first;
        sec_v_nxt = conv.pair;
        sec_nxt   = conv.second;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sec_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sec_v_r <= sec_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  `CYTT_ASSERT_IMP(a_sec_behind, sec_v_r, out_v_r && !out_r.run_last,
    "second byte waiting without its first byte")
  `CYTT_ASSERT_NXT(a_sec_moves, sec_v_r && !out_stall, out_v_r && out_r.run_last,
    "second byte not sent after first beat")
  `CYTT_ASSERT_IMP(a_err_form, out_v_r && out_r.bad_char,
    out_r.run_last && out_r.string_last && (out_r.unit == '0),
    "malformed error beat")

endmodule

>>> hdl/cyrillic_text_transcoder.sv
// ----------------------------------------------------------------------------
// cyrillic_text_transcoder
// Cyrillic text transcoder between wide units and cp1251 or utf-8 bytes.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_code_unit and in_string_end, one code unit per beat
//   output channel: out_out_unit with bad_char, run_last and string_last
//   registers: direction at 0x0, code_page at 0x4; the user writes them only
//   while idle, unenforced by the block; any write restarts the string state
// path
//   a taken input beat is held in the input register, mapped, and then
//   registered in the output register, which drives out_valid
// throughput
//   one input beat per cycle while not stalled; wide to utf-8 holds the next
//   unit while its second byte waits; the output register sends both in turn
//   a held utf-8 lead byte and dropped beats of an aborted string give no result
// reset
//   rst_n low clears all valids, the lead byte and abort flag, and both registers
// stall
//   out_stall holds the output beat; the next unit waits in the input register
//   and in_stall rises only once that register is also full
// ----------------------------------------------------------------------------
module cyrillic_text_transcoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cytt_pkg::ADDR_W-1:0] paddr,
  input  logic [cytt_pkg::DATA_W-1:0] pwdata,
  output logic [cytt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cytt_pkg::UNIT_W-1:0] in_code_unit,
  input  logic                        in_string_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cytt_pkg::UNIT_W-1:0] out_out_unit,
  output logic                        out_bad_char,
  output logic                        out_run_last,
  output logic                        out_string_last
);
  import cytt_pkg::*;

  cfg_t    cfg;
  logic    clr;
  conv_t   conv;
  logic    ready;
  result_t out_res;

  cytt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clr     (clr)
  );

  cytt_conv u_conv (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .clr           (clr),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .in_string_end (in_string_end),
    .ready         (ready),
    .conv          (conv)
  );

  cytt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .conv      (conv),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_out_unit    = out_res.unit;
  assign out_bad_char    = out_res.bad_char;
  assign out_run_last    = out_res.run_last;
  assign out_string_last = out_res.string_last;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Cyrillic text transcoder. Directed strings cover each
// direction and code page, the ends of the letter ranges, unsupported
// characters, aborted strings and truncated utf-8 pairs. Random strings,
// mostly well formed with some noise, then run under all register settings
// while both channels idle and stall in bursts. A predictor of the string
// state builds the expected beats, which are checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cytt_pkg::*;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ADDR_W-1:0]   paddr           = '0;
  logic [DATA_W-1:0]   pwdata          = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [UNIT_W-1:0]   in_code_unit    = '0;
  logic                in_string_end   = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [UNIT_W-1:0]   out_out_unit;
  logic                out_bad_char;
  logic                out_run_last;
  logic                out_string_last;

  // string state mirrored by the predictor
  dir_t                mode_dir        = DIR_DECODE;
  page_t               mode_page       = PAGE_CP1251;
  logic [BYTE_W-1:0]   lead_hold       = '0;
  logic                lead_waiting    = 1'b0;
  logic                skipping_string = 1'b0;

  result_t             pending_chars[$];
  int                  mismatch_count  = 0;
  int                  counted_units   = 0;
  bit                  feed_gaps       = 1'b0;
  bit                  stall_on        = 1'b0;
  int                  stall_left      = 0;

  cyrillic_text_transcoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_unit    (in_code_unit),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_unit    (out_out_unit),
    .out_bad_char    (out_bad_char),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // letter mapping
  function automatic bit cp_byte_to_letter(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    if (b >= 8'hC0) begin
      w = 16'h0410 + 16'(b - 8'hC0);
      return 1'b1;
    end
    if (b == 8'hA8) begin
      w = 16'h0401;
      return 1'b1;
    end
    if (b == 8'hB8) begin
      w = 16'h0451;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit utf8_pair_to_letter(input logic [15:0] v, output logic [15:0] w);
    w = '0;
    if (v >= 16'hD090 && v <= 16'hD0BF) begin
      w = 16'h0410 + (v - 16'hD090);
      return 1'b1;
    end
    if (v >= 16'hD180 && v <= 16'hD18F) begin
      w = 16'h0440 + (v - 16'hD180);
      return 1'b1;
    end
    if (v == 16'hD081) begin
      w = 16'h0401;
      return 1'b1;
    end
    if (v == 16'hD191) begin
      w = 16'h0451;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit letter_to_cp_byte(input logic [15:0] w, output logic [15:0] b);
    b = '0;
    if (w >= 16'h0410 && w <= 16'h044F) begin
      b = 16'h00C0 + (w - 16'h0410);
      return 1'b1;
    end
    if (w == 16'h0401) begin
      b = 16'h00A8;
      return 1'b1;
    end
    if (w == 16'h0451) begin
      b = 16'h00B8;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit letter_to_utf8_pair(input logic [15:0] w, output logic [15:0] p);
    p = '0;
    if (w >= 16'h0410 && w <= 16'h043F) begin
      p = 16'hD090 + (w - 16'h0410);
      return 1'b1;
    end
    if (w >= 16'h0440 && w <= 16'h044F) begin
      p = 16'hD180 + (w - 16'h0440);
      return 1'b1;
    end
    if (w == 16'h0401) begin
      p = 16'hD081;
      return 1'b1;
    end
    if (w == 16'h0451) begin
      p = 16'hD191;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void expect_char(input logic [15:0] unit, input logic bad,
                                      input logic rl, input logic sl);
    result_t r;
    r.unit        = unit;
    r.bad_char    = bad;
    r.run_last    = rl;
    r.string_last = sl;
    pending_chars = {pending_chars, r};
  endfunction

  function automatic void reject_char(input logic last);
    lead_waiting    = 1'b0;
    lead_hold       = '0;
    skipping_string = !last;
    expect_char(16'h0000, 1'b1, 1'b1, 1'b1);
  endfunction

  function automatic void transcode_unit(input logic [15:0] u, input logic last);
    logic [15:0] w;
    logic [15:0] pair;
    counted_units++;
    if (skipping_string) begin
      if (last) skipping_string = 1'b0;
      return;
    end
    if (mode_dir == DIR_DECODE) begin
      if (lead_waiting) begin
        pair         = {lead_hold, u[7:0]};
        lead_waiting = 1'b0;
        lead_hold    = '0;
        if (u > 16'h00FF || !utf8_pair_to_letter(pair, w)) reject_char(last);
        else expect_char(w, 1'b0, 1'b1, last);
      end else if (u < 16'h0080) begin
        expect_char(u, 1'b0, 1'b1, last);
      end else if (u > 16'h00FF) begin
        reject_char(last);
      end else if (mode_page == PAGE_CP1251) begin
        if (cp_byte_to_letter(u[7:0], w)) expect_char(w, 1'b0, 1'b1, last);
        else reject_char(last);
      end else if (last) begin
        reject_char(last);
      end else begin
        lead_hold    = u[7:0];
        lead_waiting = 1'b1;
      end
    end else begin
      if (u < 16'h0080) begin
        expect_char(u, 1'b0, 1'b1, last);
      end else if (mode_page == PAGE_CP1251) begin
        if (letter_to_cp_byte(u, w)) expect_char(w, 1'b0, 1'b1, last);
        else reject_char(last);
      end else if (letter_to_utf8_pair(u, w)) begin
        expect_char({8'h00, w[15:8]}, 1'b0, 1'b0, 1'b0);
        expect_char({8'h00, w[7:0]}, 1'b0, 1'b1, last);
      end else begin
        reject_char(last);
      end
    end
  endfunction

  // result side: random stall bursts
  always @(posedge clk) begin : stall_gen
    logic hold;
    hold = 1'b0;
    if (stall_left != 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      hold = 1'b1;
    end
    out_stall <= hold;
  end

  always @(posedge clk) begin : check_beat
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.unit        = out_out_unit;
      got.bad_char    = out_bad_char;
      got.run_last    = out_run_last;
      got.string_last = out_string_last;
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: unit %h bad %b run_last %b string_last %b",
                   got.unit, got.bad_char, got.run_last, got.string_last);
      end else begin
        want = pending_chars.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected unit %h bad %b rl %b sl %b, ",
                      "got unit %h bad %b rl %b sl %b"},
                     want.unit, want.bad_char, want.run_last, want.string_last,
                     got.unit, got.bad_char, got.run_last, got.string_last);
        end
      end
    end
  end

  task automatic send_unit(input logic [15:0] u, input logic last);
    int gap;
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_code_unit  <= u;
    in_string_end <= last;
    do @(posedge clk); while (in_stall);
    transcode_unit(u, last);
  endtask

  task automatic send_text(input logic [15:0] text[$]);
    foreach (text[i]) send_unit(text[i], i == text.size() - 1);
  endtask

  // drop valid, let every expected beat arrive, then cover held-lead latency
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(input reg_idx_t idx, input logic v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DIRECTION) mode_dir = dir_t'(v);
    else mode_page = page_t'(v);
    lead_waiting    = 1'b0;
    lead_hold       = '0;
    skipping_string = 1'b0;
  endtask

  function automatic logic [15:0] random_letter();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 127));
      3:       return 16'h0401;
      4:       return 16'h0451;
      default: return 16'h0410 + 16'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [15:0] noise_unit();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(128, 255));
      default: return 16'($urandom_range(16'h0400, 16'h045F));
    endcase
  endfunction

  task automatic send_string(input int len);
    logic [15:0] text[$];
    logic [15:0] w;
    logic [15:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        text = {text, noise_unit()};
      end else begin
        w = random_letter();
        if (mode_dir == DIR_ENCODE || w < 16'h0080) begin
          text = {text, w};
        end else if (mode_page == PAGE_CP1251) begin
          void'(letter_to_cp_byte(w, b));
          text = {text, b};
        end else begin
          void'(letter_to_utf8_pair(w, b));
          text = {text, {8'h00, b[15:8]}};
          text = {text, {8'h00, b[7:0]}};
        end
      end
    end
    // lone lead byte left at the end of the string
    if (mode_dir == DIR_DECODE && mode_page == PAGE_UTF8 && $urandom_range(0, 19) == 0)
      text = {text, 16'h00D0 + 16'($urandom_range(0, 1))};
    send_text(text);
  endtask

  task automatic test_decode_cp1251();
    set_register(REG_DIRECTION, DIR_DECODE);
    set_register(REG_CODE_PAGE, PAGE_CP1251);
    send_text('{16'h0000, 16'h007F, 16'h00A8, 16'h00B8, 16'h00C0, 16'h00FF});
    // unsupported byte aborts the rest of the string
    send_text('{16'h0080, 16'h0041, 16'h00C0});
    send_text('{16'hFFFF});
  endtask

  task automatic test_decode_utf8();
    set_register(REG_CODE_PAGE, PAGE_UTF8);
    send_text('{16'h00D0, 16'h0090, 16'h00D1, 16'h008F, 16'h00D0, 16'h0081,
                16'h00D1, 16'h0091});
    send_text('{16'h00D0});
    send_text('{16'h00D0, 16'h0041});
    send_text('{16'h007F});
  endtask

  task automatic test_encode_cp1251();
    set_register(REG_DIRECTION, DIR_ENCODE);
    set_register(REG_CODE_PAGE, PAGE_CP1251);
    send_text('{16'h0000, 16'h0410, 16'h044F, 16'h0401, 16'h0451});
    send_text('{16'h8000});
  endtask

  task automatic test_encode_utf8();
    set_register(REG_CODE_PAGE, PAGE_UTF8);
    send_text('{16'h0410, 16'h043F, 16'h0440, 16'h044F, 16'h0401, 16'h0451, 16'h007F});
    send_text('{16'hFFFF, 16'h0041});
  endtask

  task automatic test_random_traffic();
    int phase;
    int goal;
    phase = 0;
    while (counted_units < 1650) begin
      set_register(REG_DIRECTION, phase[0]);
      set_register(REG_CODE_PAGE, phase[1]);
      if (counted_units >= 1450) begin
        feed_gaps = 1'b0;
        stall_on  = 1'b0;
      end else begin
        feed_gaps = $urandom_range(0, 3) != 0;
        stall_on  = $urandom_range(0, 3) != 0;
      end
      goal = counted_units + 140;
      while (counted_units < goal) send_string($urandom_range(1, 12));
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    feed_gaps = 1'b1;
    stall_on  = 1'b1;
    test_decode_cp1251();
    test_decode_utf8();
    test_encode_cp1251();
    test_encode_utf8();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
